// ===== src/lfbp_pkg.sv =====
// lfbp_pkg: shared constants and types for the lsb-first bit packer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lfbp_pkg;

  // widest field one transaction can append
  localparam int unsigned MaxFieldWidth = 64;
  localparam int unsigned FieldBitsW    = 64;
  localparam int unsigned FieldWidthW   = 7;
  localparam int unsigned PendW         = 7;
  localparam int unsigned PendCntW      = 3;

  // pending bits plus one full field
  localparam int unsigned CombW   = MaxFieldWidth + PendW;
  localparam int unsigned TotalW  = $clog2(CombW + 1);
  localparam int unsigned MaxBytes = (MaxFieldWidth + PendW) / 8;
  localparam int unsigned BufW    = MaxBytes * 8;
  localparam int unsigned CountW  = $clog2(MaxBytes + 1);
  localparam int unsigned ShiftW  = CountW + 3;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  // completed bytes of one transaction, low byte first
  typedef struct packed {
    logic [BufW-1:0]   bytes;
    logic [CountW-1:0] nbytes;
  } pack_t;

endpackage

`default_nettype wire

// ===== src/lfbp_pack.sv =====
// lfbp_pack: merges a field with the pending bits and keeps the pending state
// depends on lfbp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfbp_pack (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire logic                            operation_i,
  input  wire logic [lfbp_pkg::FieldBitsW-1:0] field_bits_i,
  input  wire logic [lfbp_pkg::FieldWidthW-1:0] field_width_i,
  output lfbp_pkg::pack_t                      pack_o
);

  logic [lfbp_pkg::PendW-1:0]         pend_bits_q, pend_bits_d;
  logic [lfbp_pkg::PendCntW-1:0]      pend_cnt_q, pend_cnt_d;
  logic [lfbp_pkg::FieldWidthW-1:0]   width_clamped;
  logic [lfbp_pkg::MaxFieldWidth-1:0] val_masked;
  logic [lfbp_pkg::CombW-1:0]         comb;
  logic [lfbp_pkg::CombW-1:0]         tail;
  logic [lfbp_pkg::TotalW-1:0]        total;
  logic [lfbp_pkg::CountW-1:0]        nbytes;
  logic [2:0]                         rem;
  logic [lfbp_pkg::ShiftW-1:0]        shamt;

  always_comb begin
    // widths beyond the maximum act as the maximum
    if (field_width_i > lfbp_pkg::FieldWidthW'(lfbp_pkg::MaxFieldWidth)) begin
      width_clamped = lfbp_pkg::FieldWidthW'(lfbp_pkg::MaxFieldWidth);
    end else begin
      width_clamped = field_width_i;
    end
    // a shift by the full width leaves an all-ones mask
    val_masked = field_bits_i[lfbp_pkg::MaxFieldWidth-1:0]
               & ~({lfbp_pkg::MaxFieldWidth{1'b1}} << width_clamped);
    comb = (lfbp_pkg::CombW'(val_masked) << pend_cnt_q)
         | lfbp_pkg::CombW'(pend_bits_q);
    total  = lfbp_pkg::TotalW'(pend_cnt_q) + lfbp_pkg::TotalW'(width_clamped);
    nbytes = lfbp_pkg::CountW'(total >> 3);
    rem    = total[2:0];
    shamt  = {nbytes, 3'b000};
    tail   = comb >> shamt;
  end

  always_comb begin
    pack_o.bytes  = comb[lfbp_pkg::BufW-1:0];
    pack_o.nbytes = nbytes;
    pend_bits_d   = tail[lfbp_pkg::PendW-1:0] & ~({lfbp_pkg::PendW{1'b1}} << rem);
    pend_cnt_d    = rem;
    if (operation_i == lfbp_pkg::OP_FLUSH) begin
      // partial byte goes out zero padded
      pack_o.bytes  = lfbp_pkg::BufW'(pend_bits_q);
      pack_o.nbytes = (pend_cnt_q != '0) ? lfbp_pkg::CountW'(1) : '0;
      pend_bits_d   = '0;
      pend_cnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else if (load_i) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/lfbp_serializer.sv =====
// lfbp_serializer: holds one transaction's bytes, sends one a cycle while ready
// depends on lfbp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfbp_serializer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  lfbp_pkg::pack_t      pack_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 last_of_item_o
);

  logic [lfbp_pkg::BufW-1:0]   buf_q, buf_d;
  logic [lfbp_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                        pop;

  assign out_valid_o    = (cnt_q != '0);
  assign out_byte_o     = buf_q[7:0];
  assign last_of_item_o = (cnt_q == lfbp_pkg::CountW'(1));
  assign pop            = out_valid_o && out_ready_i;
  // free now, or the final byte leaves this cycle
  assign can_load_o     = (cnt_q == '0) || (last_of_item_o && out_ready_i);

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load_i) begin
      buf_d = pack_i.bytes;
      cnt_d = pack_i.nbytes;
    end else if (pop) begin
      buf_d = buf_q >> 8;
      cnt_d = cnt_q - lfbp_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/lsb_first_bit_packer.sv =====
// the first byte of a transaction is offered in the cycle after it is accepted, from the byte register
// a new transaction is taken once the byte register is empty or its final byte is leaving;
//   a transaction completes 0..8 bytes, sent one byte per cycle while the receiver is ready
// a transaction that completes no byte offers nothing
// reset (rst_ni low, asynchronous) clears the pending bits and empties the byte register
`timescale 1ns / 1ps
`default_nettype none

// top level: lsb-first variable width bit packer
// depends on lfbp_pkg, lfbp_pack and lfbp_serializer
module lsb_first_bit_packer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             operation_i,
  input  wire logic [lfbp_pkg::FieldBitsW-1:0]  field_bits_i,
  input  wire logic [lfbp_pkg::FieldWidthW-1:0] field_width_i,
  // output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [7:0]                            out_byte_o,
  output logic                                  last_of_item_o
);

  logic            can_load;
  logic            load;
  lfbp_pkg::pack_t pack;

  // a transaction is taken whenever the byte register is free or about to be
  assign in_ready_o = can_load;
  assign load       = in_valid_i && can_load;

  // merge the field with the pending bits; pending state advances on load
  lfbp_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .operation_i   (operation_i),
    .field_bits_i  (field_bits_i),
    .field_width_i (field_width_i),
    .pack_o        (pack)
  );

  // completed bytes leave low byte first, last one marked
  lfbp_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .pack_i         (pack),
    .can_load_o     (can_load),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_lsb_first_bit_packer.sv =====
// tb_lsb_first_bit_packer: self-checking bench for the lsb-first bit packer
// predicts the byte stream from each accepted transaction and compares every byte
// depends on lfbp_pkg and lsb_first_bit_packer
`timescale 1ns / 1ps

module tb_lsb_first_bit_packer;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 240;
  localparam int unsigned RandomPerPhase = 46;

  // one packed byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  // tracks the pending bits and queues the bytes each transaction completes
  class packed_stream_model;
    logic [lfbp_pkg::PendW-1:0]    pend_bits;
    logic [lfbp_pkg::PendCntW-1:0] pend_cnt;
    packed_byte_t                  expected_bytes[$];
    int unsigned                   errors;

    function new();
      pend_bits = '0;
      pend_cnt  = '0;
      errors    = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int unsigned outstanding();
      return expected_bytes.size();
    endfunction

    function void note_transaction(lfbp_pkg::op_e op,
                                   logic [lfbp_pkg::FieldBitsW-1:0] bits,
                                   logic [lfbp_pkg::FieldWidthW-1:0] width);
      logic [127:0]                    joined;
      logic [127:0]                    rest;
      logic [lfbp_pkg::FieldBitsW-1:0] masked;
      int unsigned                     w;
      int unsigned                     total;
      int unsigned                     nbytes;
      int unsigned                     rem;
      packed_byte_t                    b;
      if (op == lfbp_pkg::OP_FLUSH) begin
        // partial byte goes out zero-padded at the top
        if (pend_cnt != 0) begin
          b.data = {1'b0, pend_bits};
          b.last = 1'b1;
          expected_bytes.push_back(b);
        end
        pend_bits = '0;
        pend_cnt  = '0;
        return;
      end
      w = (width > lfbp_pkg::MaxFieldWidth) ? lfbp_pkg::MaxFieldWidth : width;
      if (w == 0) return;
      masked = (w == 64) ? bits : bits & ((64'd1 << w) - 64'd1);
      joined = ({64'd0, masked} << pend_cnt) | {121'd0, pend_bits};
      total  = pend_cnt + w;
      nbytes = total / 8;
      rem    = total % 8;
      for (int k = 0; k < nbytes; k++) begin
        b.data = joined[8*k +: 8];
        b.last = (k == nbytes - 1);
        expected_bytes.push_back(b);
      end
      rest      = joined >> (8 * nbytes);
      pend_bits = rest[6:0] & ((7'd1 << rem) - 7'd1);
      pend_cnt  = rem[2:0];
    endfunction

    task check_byte(logic [7:0] data, logic last);
      packed_byte_t e;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", data, last));
        return;
      end
      e = expected_bytes.pop_front();
      if (data !== e.data)
        report($sformatf("out_byte %02h, want %02h", data, e.data));
      if (last !== e.last)
        report($sformatf("last_of_item %0b, want %0b (byte %02h)", last, e.last, e.data));
    endtask
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic                             operation_i;
  logic [lfbp_pkg::FieldBitsW-1:0]  field_bits_i;
  logic [lfbp_pkg::FieldWidthW-1:0] field_width_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  logic [7:0]                       out_byte_o;
  logic                             last_of_item_o;

  packed_stream_model stream;

  // idle odds in percent, changed by the main sequence per phase
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // long receiver stall, requested once by the main sequence
  logic        stall_request;
  logic        stall_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  lsb_first_bit_packer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .field_bits_i   (field_bits_i),
    .field_width_i  (field_width_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // receiver side: random ready at the falling edge, or a long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_request && !stall_taken) begin
      stall_taken = 1'b1;
      hold_left   = HoldCycles - 1;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // every byte taken at a rising edge is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      stream.check_byte(out_byte_o, last_of_item_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, stream.outstanding());
      $display("tb_lsb_first_bit_packer: done, errors");
      $finish;
    end
  end

  // offers one transaction from a falling edge and returns at the falling edge
  // after it was accepted, with valid still high
  task send_item(lfbp_pkg::op_e op, logic [lfbp_pkg::FieldBitsW-1:0] bits,
                 logic [lfbp_pkg::FieldWidthW-1:0] width);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    field_bits_i  <= bits;
    field_width_i <= width;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    stream.note_transaction(op, bits, width);
    @(negedge clk_i);
  endtask

  function logic [lfbp_pkg::FieldBitsW-1:0] random_bits();
    return {$urandom, $urandom};
  endfunction

  // mostly appends of mixed widths, with flushes, empty and oversized widths mixed in
  task send_random_item();
    int unsigned pick;
    logic [lfbp_pkg::FieldWidthW-1:0] width;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_item(lfbp_pkg::OP_FLUSH, random_bits(),
                lfbp_pkg::FieldWidthW'($urandom_range(127)));
    end else begin
      pick = $urandom_range(99);
      if (pick < 6)       width = '0;
      else if (pick < 18) width = 7'd64;
      else if (pick < 24) width = lfbp_pkg::FieldWidthW'($urandom_range(65, 127));
      else if (pick < 60) width = lfbp_pkg::FieldWidthW'($urandom_range(1, 8));
      else                width = lfbp_pkg::FieldWidthW'($urandom_range(9, 63));
      send_item(lfbp_pkg::OP_APPEND, random_bits(), width);
    end
  endtask

  initial begin
    stream        = new();
    stall_request = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 51;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    operation_i   = lfbp_pkg::OP_APPEND;
    field_bits_i  = '0;
    field_width_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: full 64-bit field with nothing pending leaves nothing pending
    send_item(lfbp_pkg::OP_APPEND, '1, 7'd64);
    // flush with nothing pending and a zero-width append both emit nothing
    send_item(lfbp_pkg::OP_FLUSH, '1, 7'd127);
    send_item(lfbp_pkg::OP_APPEND, '1, 7'd0);
    // bits above the width must not leak into the pending bits
    send_item(lfbp_pkg::OP_APPEND, 64'hFFFF_FFFF_FFFF_FFF5, 7'd3);
    send_item(lfbp_pkg::OP_APPEND, '0, 7'd64);
    send_item(lfbp_pkg::OP_APPEND, '1, 7'd64);
    send_item(lfbp_pkg::OP_FLUSH, '0, 7'd0);
    send_item(lfbp_pkg::OP_FLUSH, '0, 7'd0);
    // seven pending bits completed by a single bit
    send_item(lfbp_pkg::OP_APPEND, '1, 7'd7);
    send_item(lfbp_pkg::OP_APPEND, '0, 7'd1);
    // seven pending plus a full field: eight bytes and seven left over
    send_item(lfbp_pkg::OP_APPEND, 64'h55, 7'd7);
    send_item(lfbp_pkg::OP_APPEND, 64'hA5A5_5A5A_F00F_0FF0, 7'd64);
    send_item(lfbp_pkg::OP_FLUSH, '1, 7'd64);
    // oversized widths are clamped to a full field
    send_item(lfbp_pkg::OP_APPEND, 64'h0123_4567_89AB_CDEF, 7'd65);
    send_item(lfbp_pkg::OP_APPEND, 64'h1, 7'd5);
    send_item(lfbp_pkg::OP_APPEND, 64'hFEDC_BA98_7654_3210, 7'd127);
    send_item(lfbp_pkg::OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 7'd100);
    send_item(lfbp_pkg::OP_FLUSH, '0, 7'd0);
    // exact byte, then odd sizes and a closing flush
    send_item(lfbp_pkg::OP_APPEND, 64'hA5, 7'd8);
    send_item(lfbp_pkg::OP_APPEND, 64'h1, 7'd1);
    send_item(lfbp_pkg::OP_APPEND, 64'h0, 7'd63);
    send_item(lfbp_pkg::OP_FLUSH, '1, 7'd1);

    // random phase one: sender idles less than the receiver
    repeat (RandomPerPhase) send_random_item();

    // random phase two: the other way round
    send_idle_pct = 51;
    recv_idle_pct = 24;
    repeat (RandomPerPhase) send_random_item();

    // random phase three: no idling, with one long receiver stall up front so
    // the block fills and backs up its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b1;
    repeat (RandomPerPhase) send_random_item();
    in_valid_i <= 1'b0;

    // drain, then give stray bytes a chance to show up
    while (stream.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (stream.outstanding() != 0)
      stream.report($sformatf("%0d bytes never arrived", stream.outstanding()));

    if (stream.errors == 0) begin
      $display("tb_lsb_first_bit_packer: done, clean");
    end else begin
      $display("tb_lsb_first_bit_packer: done, errors");
    end
    $finish;
  end

endmodule

// ===== lsb_first_bit_packer.f =====
src/lfbp_pkg.sv
src/lfbp_pack.sv
src/lfbp_serializer.sv
src/lsb_first_bit_packer.sv
tb/tb_lsb_first_bit_packer.sv
